// File: rtl/core/xtea_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

  localparam int WORD_W     = 32;
  localparam int KEY_WORDS  = 4;
  localparam int KSEL_W     = $clog2(KEY_WORDS);
  localparam int ROUNDS_DEF = 32;

  localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  localparam logic [KSEL_W-1:0] KEY_IDX0 = 2'd0;
  localparam logic [KSEL_W-1:0] KEY_IDX1 = 2'd1;
  localparam logic [KSEL_W-1:0] KEY_IDX2 = 2'd2;
  localparam logic [KSEL_W-1:0] KEY_IDX3 = 2'd3;

  typedef logic [KEY_WORDS-1:0][WORD_W-1:0] key_arr_t;

  typedef struct packed {
    logic              func;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } blk_t;

  function automatic logic [WORD_W-1:0] sum_at(input int unsigned k);
    logic [63:0] p;
    p = 64'(k) * 64'(DELTA);
    return p[WORD_W-1:0];
  endfunction

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/xtea_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface xtea_in_if;
  import xtea_pkg::*;
  logic              valid;
  logic              ready;
  logic              func;
  logic [WORD_W-1:0] first_word;
  logic [WORD_W-1:0] second_word;

  modport source (output valid, func, first_word, second_word, input ready);
  modport sink (input valid, func, first_word, second_word, output ready);
endinterface

interface xtea_out_if;
  import xtea_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_first_word;
  logic [WORD_W-1:0] out_second_word;

  modport source (output valid, out_first_word, out_second_word, input ready);
  modport sink (input valid, out_first_word, out_second_word, output ready);
endinterface

interface xtea_cfg_if;
  import xtea_pkg::*;
  logic              valid;
  logic              ready;
  logic [KSEL_W-1:0] index;
  logic [WORD_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/xtea_round.sv
`timescale 1ns / 1ps
`default_nettype none

module xtea_round import xtea_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF,
  parameter int STAGE  = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_vld,
  output logic     up_rdy,
  input  blk_t     up_blk,
  input  key_arr_t key,
  output logic     dn_vld,
  input  logic     dn_rdy,
  output blk_t     dn_blk
);

  localparam int          N      = STAGE / 2;
  localparam logic        SECOND = 1'(STAGE % 2);
  localparam logic [WORD_W-1:0] ENC_SUM = SECOND ? sum_at(N + 1) : sum_at(N);
  localparam logic [WORD_W-1:0] DEC_SUM = SECOND ? sum_at(ROUNDS - N - 1) : sum_at(ROUNDS - N);
  localparam logic [KSEL_W-1:0] ENC_KSEL = SECOND ? ENC_SUM[12:11] : ENC_SUM[1:0];
  localparam logic [KSEL_W-1:0] DEC_KSEL = SECOND ? DEC_SUM[1:0] : DEC_SUM[12:11];

  logic              vld_r;
  blk_t              blk_r;
  blk_t              blk_nxt;
  logic              use_y;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] kword;
  logic [WORD_W-1:0] f;
  logic [WORD_W-1:0] res;

  always_comb begin
    use_y = up_blk.func ^ SECOND;
    src   = use_y ? up_blk.y : up_blk.z;
    dst   = use_y ? up_blk.z : up_blk.y;
    sum   = (up_blk.func == FUNC_DEC) ? DEC_SUM : ENC_SUM;
    kword = (up_blk.func == FUNC_DEC) ? key[DEC_KSEL] : key[ENC_KSEL];
    f     = mix(src) ^ (sum + kword);
    res   = (up_blk.func == FUNC_DEC) ? dst - f : dst + f;
    blk_nxt      = up_blk;
    if (use_y) begin
      blk_nxt.z = res;
    end else begin
      blk_nxt.y = res;
    end
  end

  assign up_rdy = !vld_r || dn_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_rdy) begin
      vld_r <= up_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy && up_vld) begin
      blk_r <= blk_nxt;
    end
  end

  assign dn_vld = vld_r;
  assign dn_blk = blk_r;

endmodule

`default_nettype wire

// File: rtl/core/xtea_block_cipher_core.sv
// XTEA block cipher core, 64-bit block, 128-bit key.
// Requests arrive on in_ch: func selects encipher or decipher, first_word and
// second_word carry the two halves of the block. Results leave on out_ch as
// out_first_word and out_second_word, in the order the requests were taken.
// The four key words are written on cfg_ch, index 0 to 3, and must only be
// changed while no request is in flight; cfg_ch is always ready.
// Each half-round is one register stage, so a request passes 2*ROUNDS
// registers on its way from in_ch to out_ch. One request is accepted every
// cycle while the receiver keeps taking results.
// The last stage holds the result until out_ch.ready is seen. While the
// receiver stalls, empty stages keep filling, and in_ch.ready falls only
// once every stage holds a request; nothing is lost or repeated.
// Synchronous reset empties the pipeline and clears the key words to zero.
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher_core import xtea_pkg::*; #(
  parameter int ROUNDS = ROUNDS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  xtea_in_if.sink    in_ch,
  xtea_out_if.source out_ch,
  xtea_cfg_if.sink   cfg_ch
);

  localparam int NSTAGE = 2 * ROUNDS;

  key_arr_t          key_r;
  logic [NSTAGE:0]   vld;
  logic [NSTAGE:0]   rdy;
  blk_t              blk [NSTAGE+1];

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        KEY_IDX0: key_r[0] <= cfg_ch.data;
        KEY_IDX1: key_r[1] <= cfg_ch.data;
        KEY_IDX2: key_r[2] <= cfg_ch.data;
        KEY_IDX3: key_r[3] <= cfg_ch.data;
        default:  key_r    <= key_r;
      endcase
    end
  end

  assign vld[0]       = in_ch.valid;
  assign in_ch.ready  = rdy[0];
  assign blk[0].func  = in_ch.func;
  assign blk[0].y     = in_ch.first_word;
  assign blk[0].z     = in_ch.second_word;

  for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
    xtea_round #(
      .ROUNDS(ROUNDS),
      .STAGE (s)
    ) u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .up_vld(vld[s]),
      .up_rdy(rdy[s]),
      .up_blk(blk[s]),
      .key   (key_r),
      .dn_vld(vld[s+1]),
      .dn_rdy(rdy[s+1]),
      .dn_blk(blk[s+1])
    );
  end

  assign rdy[NSTAGE]            = out_ch.ready;
  assign out_ch.valid           = vld[NSTAGE];
  assign out_ch.out_first_word  = blk[NSTAGE].y;
  assign out_ch.out_second_word = blk[NSTAGE].z;

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("pipeline not empty after reset");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld[NSTAGE:1]))
    else $error("input stalled with an empty stage");

  a_first_stage_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld[1])
    else $error("accepted request not in first stage");

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import xtea_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;
  } cipher_out_t;

  logic clk = 1'b0;
  logic rst_n;

  xtea_in_if  in_ch();
  xtea_out_if out_ch();
  xtea_cfg_if cfg_ch();

  xtea_block_cipher_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [WORD_W-1:0] key_model [KEY_WORDS];
  cipher_out_t       block_results [$];
  int                fail_count = 0;
  int                cycle_count = 0;
  bit                idle_on = 1'b1;

  always #1 clk = ~clk;

  function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] x);
    return ({x[WORD_W-5:0], 4'b0000} ^ {5'b00000, x[WORD_W-1:5]}) + x;
  endfunction

  function automatic cipher_out_t predict_block(input logic func,
                                                input logic [WORD_W-1:0] y_in,
                                                input logic [WORD_W-1:0] z_in);
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic [WORD_W-1:0] sum;
    cipher_out_t       res;
    int                n;
    y = y_in;
    z = z_in;
    if (func == FUNC_ENC) begin
      sum = '0;
      for (n = 0; n < ROUNDS_DEF; n++) begin
        y = y + (round_mix(z) ^ (sum + key_model[sum[1:0]]));
        sum = sum + DELTA;
        z = z + (round_mix(y) ^ (sum + key_model[sum[12:11]]));
      end
    end else begin
      sum = WORD_W'(64'(DELTA) * ROUNDS_DEF);
      for (n = 0; n < ROUNDS_DEF; n++) begin
        z = z - (round_mix(y) ^ (sum + key_model[sum[12:11]]));
        sum = sum - DELTA;
        y = y - (round_mix(z) ^ (sum + key_model[sum[1:0]]));
      end
    end
    res.first_word = y;
    res.second_word = z;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  // Each request is pushed with its predicted block at the edge where it is taken.
  task automatic send_block(input logic func, input logic [WORD_W-1:0] a,
                            input logic [WORD_W-1:0] b);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      in_ch.func = $urandom_range(0, 1);
      in_ch.first_word = $urandom;
      in_ch.second_word = $urandom;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = func;
    in_ch.first_word = a;
    in_ch.second_word = b;
    do @(posedge clk); while (!in_ch.ready);
    block_results.push_back(predict_block(func, a, b));
  endtask

  task automatic drain_blocks();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (block_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_key(input int idx, input logic [WORD_W-1:0] val);
    @(negedge clk);
    in_ch.valid = 1'b0;
    cfg_ch.valid = 1'b1;
    cfg_ch.index = KSEL_W'(idx);
    cfg_ch.data = val;
    do @(posedge clk); while (!cfg_ch.ready);
    key_model[idx] = val;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  endtask

  task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                          input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
    drain_blocks();
    write_key(KEY_IDX0, k0);
    write_key(KEY_IDX1, k1);
    write_key(KEY_IDX2, k2);
    write_key(KEY_IDX3, k3);
  endtask

  task automatic send_extremes();
    send_block(FUNC_ENC, '0, '0);
    send_block(FUNC_DEC, '0, '0);
    send_block(FUNC_ENC, '1, '1);
    send_block(FUNC_DEC, '1, '1);
    send_block(FUNC_ENC, '0, '1);
    send_block(FUNC_DEC, '1, '0);
  endtask

  task automatic test_reset_key();
    send_extremes();
  endtask

  task automatic test_key_extremes();
    load_key('1, '1, '1, '1);
    send_extremes();
    load_key(32'h0000_0001, 32'h8000_0000, '0, '1);
    send_block(FUNC_ENC, 32'h8000_0000, 32'h0000_0001);
    send_block(FUNC_DEC, 32'h0000_0001, 32'h8000_0000);
  endtask

  task automatic test_round_trip();
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    cipher_out_t       c;
    int                i;
    load_key(32'h0001_0203, 32'h0405_0607, 32'h0809_0a0b, 32'h0c0d_0e0f);
    for (i = 0; i < 5; i++) begin
      a = $urandom;
      b = $urandom;
      c = predict_block(FUNC_ENC, a, b);
      send_block(FUNC_ENC, a, b);
      send_block(FUNC_DEC, c.first_word, c.second_word);
    end
  endtask

  task automatic test_random_keys();
    int phase;
    int i;
    for (phase = 0; phase < 5; phase++) begin
      load_key($urandom, $urandom, $urandom, $urandom);
      for (i = 0; i < 220; i++)
        send_block($urandom_range(0, 1), pick_word(), pick_word());
    end
  endtask

  task automatic test_back_to_back();
    int i;
    load_key($urandom, $urandom, $urandom, $urandom);
    idle_on = 1'b0;
    for (i = 0; i < 200; i++)
      send_block($urandom_range(0, 1), $urandom, $urandom);
  endtask

  always begin
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ch.ready = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    out_ch.ready = 1'b1;
  end

  always @(posedge clk) begin
    cipher_out_t exp_blk;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (block_results.size() == 0) begin
        $error("result with no request outstanding: %h %h",
               out_ch.out_first_word, out_ch.out_second_word);
        fail_count++;
      end else begin
        exp_blk = block_results.pop_front();
        if (out_ch.out_first_word !== exp_blk.first_word) begin
          $error("out_first_word expected %h actual %h",
                 exp_blk.first_word, out_ch.out_first_word);
          fail_count++;
        end
        if (out_ch.out_second_word !== exp_blk.second_word) begin
          $error("out_second_word expected %h actual %h",
                 exp_blk.second_word, out_ch.out_second_word);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[xtea_block_cipher_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_ENC;
    in_ch.first_word = '0;
    in_ch.second_word = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    for (int k = 0; k < KEY_WORDS; k++) key_model[k] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_key();
    test_key_extremes();
    test_round_trip();
    test_random_keys();
    test_back_to_back();

    drain_blocks();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && block_results.size() == 0) begin
      $display("[xtea_block_cipher_core] OK");
    end else begin
      $display("[xtea_block_cipher_core] ERROR");
    end
    $finish;
  end

endmodule
